// ===== hdl/rblc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ROM bank page cache package
// Sizes, transaction types, outcome codes and the slot entry layout shared by
// the cache controller and its checker; the tag memory is sized from them.
// ----------------------------------------------------------------------------
package rblc_pkg;

  localparam int SLOTS     = 4;
  localparam int BANK_BITS = 9;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 32;

  localparam logic [1:0] OUTCOME_CURRENT = 2'd0;
  localparam logic [1:0] OUTCOME_HIT     = 2'd1;
  localparam logic [1:0] OUTCOME_MISS    = 2'd2;
  localparam logic [1:0] OUTCOME_INVAL   = 2'd3;

  localparam logic MODE_SELECT  = 1'b0;
  localparam logic MODE_NEW_ROM = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [8:0] page_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [1:0]         slot;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
  } out_t;

  typedef struct packed {
    logic [BANK_BITS-1:0] tag;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== hdl/rblc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rblc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [WIDTH-1:0]       wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  output logic      [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rom_bank_lru_page_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ROM bank LRU page cache
// Tag and replacement controller for a fully associative bank cache.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries bank requests. A select transaction (mode 0)
//   names a bank; a new-ROM transaction (mode 1) invalidates the current bank
//   and keeps the cached tags. Every input transaction yields exactly one
//   result transaction on the out_ channel with the outcome, the slot hit or
//   filled and the running hit and miss counters.
//   Tags and use stamps live in a small RAM that is scanned one slot per
//   cycle. A transaction that needs a lookup scans the slots in S_SCAN
//   until a hit or the last slot and then passes through S_DONE into the
//   output register; an invalidation or a request for the current bank goes
//   from S_IDLE straight to S_DONE. The next transaction is accepted once
//   the previous result has moved to the output register, never earlier.
//   Reset empties every slot, clears the current bank and zeroes the use
//   clock and both counters. While out_stall is high the result is held
//   unchanged; a second result waits internally and in_stall stays high.
// ----------------------------------------------------------------------------
module rom_bank_lru_page_cache (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rblc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rblc_pkg::out_t      out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [rblc_pkg::SLOT_W-1:0] LAST_SLOT = rblc_pkg::SLOT_W'(rblc_pkg::SLOTS - 1);

  state_t                             state_r, state_nxt;
  logic [rblc_pkg::SLOTS-1:0]         valid_r, valid_nxt;
  logic                               cur_valid_r, cur_valid_nxt;
  logic [rblc_pkg::BANK_BITS-1:0]     cur_bank_r, cur_bank_nxt;
  logic [rblc_pkg::BANK_BITS-1:0]     bank_r, bank_nxt;
  logic [rblc_pkg::STAMP_W-1:0]       clock_r, clock_nxt;
  logic [rblc_pkg::COUNT_W-1:0]       hits_r, hits_nxt;
  logic [rblc_pkg::COUNT_W-1:0]       misses_r, misses_nxt;
  logic [rblc_pkg::SLOT_W-1:0]        idx_r, idx_nxt;
  logic                               have_empty_r, have_empty_nxt;
  logic [rblc_pkg::SLOT_W-1:0]        empty_idx_r, empty_idx_nxt;
  logic [rblc_pkg::SLOT_W-1:0]        best_r, best_nxt;
  logic [rblc_pkg::STAMP_W-1:0]       best_stamp_r, best_stamp_nxt;
  rblc_pkg::out_t                     res_r, res_nxt;
  rblc_pkg::out_t                     out_r, out_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic                               wr_en;
  logic [rblc_pkg::SLOT_W-1:0]        wr_addr;
  rblc_pkg::entry_t                   wr_entry;
  logic [rblc_pkg::SLOT_W-1:0]        rd_addr;
  logic [rblc_pkg::ENTRY_W-1:0]       rd_data;
  rblc_pkg::entry_t                   ent;

  logic                               is_hit;
  logic                               any_empty;
  logic [rblc_pkg::SLOT_W-1:0]        empty_sel;
  logic                               less;
  logic [rblc_pkg::SLOT_W-1:0]        best_sel;
  logic [rblc_pkg::SLOT_W-1:0]        victim;
  logic [rblc_pkg::STAMP_W-1:0]       stamp_new;
  logic [rblc_pkg::BANK_BITS-1:0]     in_bank;
  logic                               in_fire;
  logic                               out_free;

  rblc_ram #(
    .WIDTH (rblc_pkg::ENTRY_W),
    .DEPTH (rblc_pkg::SLOTS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (1'b1),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent       = rblc_pkg::entry_t'(rd_data);
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign in_bank   = rblc_pkg::BANK_BITS'(in_data.page_index);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_hit    = valid_r[idx_r] && (ent.tag == bank_r);
  assign any_empty = have_empty_r || !valid_r[idx_r];
  assign empty_sel = have_empty_r ? empty_idx_r : idx_r;
  assign less      = ent.stamp < best_stamp_r;
  assign best_sel  = less ? idx_r : best_r;
  assign victim    = any_empty ? empty_sel : best_sel;
  assign stamp_new = clock_r + rblc_pkg::STAMP_W'(1);

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cur_valid_nxt  = cur_valid_r;
    cur_bank_nxt   = cur_bank_r;
    bank_nxt       = bank_r;
    clock_nxt      = clock_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    idx_nxt        = idx_r;
    have_empty_nxt = have_empty_r;
    empty_idx_nxt  = empty_idx_r;
    best_nxt       = best_r;
    best_stamp_nxt = best_stamp_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_entry       = '{tag: bank_r, stamp: stamp_new};
    rd_addr        = idx_r + rblc_pkg::SLOT_W'(1);

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_fire) begin
          bank_nxt           = in_bank;
          res_nxt.slot       = 2'd0;
          res_nxt.hit_count  = hits_r;
          res_nxt.miss_count = misses_r;
          if (in_data.mode == rblc_pkg::MODE_NEW_ROM) begin
            cur_valid_nxt   = 1'b0;
            res_nxt.outcome = rblc_pkg::OUTCOME_INVAL;
            state_nxt       = S_DONE;
          end else if (cur_valid_r && (cur_bank_r == in_bank)) begin
            res_nxt.outcome = rblc_pkg::OUTCOME_CURRENT;
            state_nxt       = S_DONE;
          end else begin
            idx_nxt        = '0;
            have_empty_nxt = 1'b0;
            empty_idx_nxt  = '0;
            best_nxt       = '0;
            best_stamp_nxt = '1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        have_empty_nxt = any_empty;
        empty_idx_nxt  = empty_sel;
        best_nxt       = best_sel;
        best_stamp_nxt = less ? ent.stamp : best_stamp_r;
        idx_nxt        = idx_r + rblc_pkg::SLOT_W'(1);
        if (is_hit) begin
          wr_en              = 1'b1;
          wr_addr            = idx_r;
          clock_nxt          = stamp_new;
          hits_nxt           = hits_r + rblc_pkg::COUNT_W'(1);
          cur_valid_nxt      = 1'b1;
          cur_bank_nxt       = bank_r;
          res_nxt.outcome    = rblc_pkg::OUTCOME_HIT;
          res_nxt.slot       = 2'(idx_r);
          res_nxt.hit_count  = hits_r + rblc_pkg::COUNT_W'(1);
          res_nxt.miss_count = misses_r;
          state_nxt          = S_DONE;
        end else if (idx_r == LAST_SLOT) begin
          wr_en              = 1'b1;
          wr_addr            = victim;
          valid_nxt[victim]  = 1'b1;
          clock_nxt          = stamp_new;
          misses_nxt         = misses_r + rblc_pkg::COUNT_W'(1);
          cur_valid_nxt      = 1'b1;
          cur_bank_nxt       = bank_r;
          res_nxt.outcome    = rblc_pkg::OUTCOME_MISS;
          res_nxt.slot       = 2'(victim);
          res_nxt.hit_count  = hits_r;
          res_nxt.miss_count = misses_r + rblc_pkg::COUNT_W'(1);
          state_nxt          = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cur_valid_r <= 1'b0;
      cur_bank_r  <= '0;
      clock_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_bank_r  <= cur_bank_nxt;
      clock_r     <= clock_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bank_r       <= bank_nxt;
    idx_r        <= idx_nxt;
    have_empty_r <= have_empty_nxt;
    empty_idx_r  <= empty_idx_nxt;
    best_r       <= best_nxt;
    best_stamp_r <= best_stamp_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/rblc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ROM bank page cache checker
// Port-level properties of the bank cache, bound to the top level.
// ----------------------------------------------------------------------------
module rblc_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire rblc_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire rblc_pkg::out_t out_data
);

  // A held result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only hits and misses name a slot.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == rblc_pkg::OUTCOME_CURRENT ||
                  out_data.outcome == rblc_pkg::OUTCOME_INVAL)
    |-> out_data.slot == 2'd0)
    else $error("slot reported for a transaction without lookup");

  // The block takes one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rom_bank_lru_page_cache rblc_checker u_rblc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
